// ===== rtl/core/right_triangle_magnitude_angles_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the right-triangle magnitude and angles block.
// Compiled out under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef RIGHT_TRIANGLE_MAGNITUDE_ANGLES_TOP_MACROS_SVH
`define RIGHT_TRIANGLE_MAGNITUDE_ANGLES_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define RTMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtma: implication check failed");

// Condition holds on every cycle out of reset.
`define RTMA_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rtma: invariant check failed");

`else

`define RTMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RTMA_ASSERT_ALWAYS(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/core/rtma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtma_pkg
// Shared widths, constants, pipeline word and arctangent table for the
// right-triangle magnitude and angles pipeline.
// ----------------------------------------------------------------------------
package rtma_pkg;

  localparam int RTMA_ITERATIONS = 16;

  // Port widths
  localparam int LEG_W = 16;
  localparam int HYP_W = 17;
  localparam int ANG_W = 15;

  // Square root datapath: 33-bit sum of squares, one root bit per stage
  localparam int SQ_W       = 2 * LEG_W;
  localparam int RAD_W      = 34;
  localparam int ROOT_W     = 35;
  localparam int SQRT_STEPS = 17;

  // CORDIC datapath: legs scaled by 2^8, angle in degrees Q7.16
  localparam int FRAC_SH   = 8;
  localparam int XY_W      = 27;
  localparam int Z_W       = 25;
  localparam int TABLE_LEN = 24;

  localparam logic signed [Z_W-1:0] DEG90_Z   = 25'sd5898240;
  localparam logic [Z_W-1:0]        Z_HALF    = 25'd128;
  localparam logic [ANG_W-1:0]      DEG90_ANG = 15'd23040;

  // Word after the squaring stage
  typedef struct packed {
    logic [SQ_W-1:0]  sq_a;
    logic [SQ_W-1:0]  sq_b;
    logic [LEG_W-1:0] leg_a;
    logic [LEG_W-1:0] leg_b;
  } rtma_sq_t;

  // Word that moves through the iteration stages
  typedef struct packed {
    logic [RAD_W-1:0]        rem;
    logic [ROOT_W-1:0]       root;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
    logic                    a_zero;
    logic                    b_zero;
  } rtma_word_t;

  // atan(2^-i) in degrees, Q7.16, rounded to nearest
  function automatic logic [Z_W-1:0] atan_deg(input int idx);
    logic [Z_W-1:0] v;
    unique case (idx)
      0:       v = 25'd2949120;
      1:       v = 25'd1740967;
      2:       v = 25'd919879;
      3:       v = 25'd466945;
      4:       v = 25'd234379;
      5:       v = 25'd117304;
      6:       v = 25'd58666;
      7:       v = 25'd29335;
      8:       v = 25'd14668;
      9:       v = 25'd7334;
      10:      v = 25'd3667;
      11:      v = 25'd1833;
      12:      v = 25'd917;
      13:      v = 25'd458;
      14:      v = 25'd229;
      15:      v = 25'd115;
      16:      v = 25'd57;
      17:      v = 25'd29;
      18:      v = 25'd14;
      19:      v = 25'd7;
      20:      v = 25'd4;
      21:      v = 25'd2;
      22:      v = 25'd1;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/rtma_square.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtma_square
// Two front stages: square both legs, then sum the squares and load the
// CORDIC start vector.
// ----------------------------------------------------------------------------
module rtma_square (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rtma_pkg::LEG_W-1:0] in_leg_a,
  input  logic [rtma_pkg::LEG_W-1:0] in_leg_b,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rtma_pkg::rtma_word_t      out_word
);
  import rtma_pkg::*;

  logic       sq_v_r;
  rtma_sq_t   sq_r;
  rtma_sq_t   sq_nxt;
  logic       word_v_r;
  rtma_word_t word_r;
  rtma_word_t word_nxt;
  logic       ready_a;
  logic       ready_b;

  // Stage holds unless empty or its consumer takes the word
  assign ready_b  = !word_v_r || out_ready;
  assign ready_a  = !sq_v_r || ready_b;
  assign in_ready = ready_a;

  // Squares
  always_comb begin
    sq_nxt.sq_a  = SQ_W'(in_leg_a) * SQ_W'(in_leg_a);
    sq_nxt.sq_b  = SQ_W'(in_leg_b) * SQ_W'(in_leg_b);
    sq_nxt.leg_a = in_leg_a;
    sq_nxt.leg_b = in_leg_b;
  end

  // Sum of squares and CORDIC start vector
  always_comb begin
    word_nxt.rem    = RAD_W'(sq_r.sq_a) + RAD_W'(sq_r.sq_b);
    word_nxt.root   = '0;
    word_nxt.x      = XY_W'({sq_r.leg_b, {FRAC_SH{1'b0}}});
    word_nxt.y      = XY_W'({sq_r.leg_a, {FRAC_SH{1'b0}}});
    word_nxt.z      = '0;
    word_nxt.a_zero = (sq_r.leg_a == '0);
    word_nxt.b_zero = (sq_r.leg_b == '0);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r   <= 1'b0;
      word_v_r <= 1'b0;
    end else begin
      if (ready_a) sq_v_r <= in_valid;
      if (ready_b) word_v_r <= sq_v_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ready_a && in_valid) sq_r <= sq_nxt;
    if (ready_b && sq_v_r) word_r <= word_nxt;
  end

  assign out_valid = word_v_r;
  assign out_word  = word_r;

endmodule

// ===== rtl/core/rtma_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtma_step
// One iteration stage: one bit of the square root and one CORDIC vectoring
// rotation, each only where STEP lies within its step count.
// ----------------------------------------------------------------------------
module rtma_step #(
  parameter int STEP       = 0,
  parameter int ITERATIONS = rtma_pkg::RTMA_ITERATIONS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rtma_pkg::rtma_word_t in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rtma_pkg::rtma_word_t out_word
);
  import rtma_pkg::*;

  localparam int  N_ITER    = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
  localparam bit  DO_SQRT   = (STEP < SQRT_STEPS);
  localparam bit  DO_CORDIC = (STEP < N_ITER);
  localparam int  SQ_SH     = DO_SQRT ? 2 * (SQRT_STEPS - 1 - STEP) : 0;
  localparam logic [ROOT_W-1:0] SQ_BIT = ROOT_W'(1) << SQ_SH;
  localparam logic signed [Z_W-1:0] ATAN_Z = atan_deg(STEP);

  logic                   v_r;
  rtma_word_t             word_r;
  rtma_word_t             word_nxt;
  logic [ROOT_W-1:0]      trial;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic                   y_pos;

  assign in_ready = !v_r || out_ready;

  assign trial = in_word.root + SQ_BIT;
  assign dx    = $signed(in_word.y) >>> STEP;
  assign dy    = $signed(in_word.x) >>> STEP;
  assign y_pos = !in_word.y[XY_W-1] && (in_word.y != '0);

  // Root bit and rotation
  always_comb begin
    word_nxt = in_word;
    if (DO_SQRT) begin
      if (ROOT_W'(in_word.rem) >= trial) begin
        word_nxt.rem  = in_word.rem - RAD_W'(trial);
        word_nxt.root = (in_word.root >> 1) + SQ_BIT;
      end else begin
        word_nxt.root = in_word.root >> 1;
      end
    end
    if (DO_CORDIC) begin
      if (y_pos) begin
        word_nxt.x = in_word.x + dx;
        word_nxt.y = in_word.y - dy;
        word_nxt.z = in_word.z + ATAN_Z;
      end else begin
        word_nxt.x = in_word.x - dx;
        word_nxt.y = in_word.y + dy;
        word_nxt.z = in_word.z - ATAN_Z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) word_r <= word_nxt;
  end

  assign out_valid = v_r;
  assign out_word  = word_r;

endmodule

// ===== rtl/core/rtma_finish.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtma_finish
// Output stage: rounds the root, clamps and rounds the angle, forms the
// complementary angle and applies the zero-leg cases.
// ----------------------------------------------------------------------------
module rtma_finish (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rtma_pkg::rtma_word_t       in_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rtma_pkg::HYP_W-1:0] out_hypotenuse,
  output logic [rtma_pkg::ANG_W-1:0] out_angle_opposite_a,
  output logic [rtma_pkg::ANG_W-1:0] out_angle_opposite_b,
  output logic                       out_degenerate
);
  import rtma_pkg::*;

  logic                   v_r;
  logic [HYP_W-1:0]       hyp_r;
  logic [HYP_W-1:0]       hyp_nxt;
  logic [ANG_W-1:0]       ang_a_r;
  logic [ANG_W-1:0]       ang_a_nxt;
  logic [ANG_W-1:0]       ang_b_r;
  logic [ANG_W-1:0]       ang_b_nxt;
  logic                   degen_r;
  logic                   degen_nxt;
  logic [HYP_W-1:0]       root_lo;
  logic signed [Z_W-1:0]  z_clamp;
  logic [Z_W-1:0]         z_sum;
  logic [ANG_W-1:0]       ang_cordic;

  assign in_ready = !v_r || out_ready;

  // Round to nearest: bump when remainder exceeds root
  assign root_lo = in_word.root[HYP_W-1:0];
  assign hyp_nxt = (ROOT_W'(in_word.rem) > in_word.root) ? root_lo + HYP_W'(1) : root_lo;

  // Clamp angle to [0, 90] degrees, then Q7.16 -> Q7.8 with rounding
  always_comb begin
    priority if (in_word.z[Z_W-1]) begin
      z_clamp = '0;
    end else if ($signed(in_word.z) > DEG90_Z) begin
      z_clamp = DEG90_Z;
    end else begin
      z_clamp = in_word.z;
    end
  end

  assign z_sum      = z_clamp + Z_HALF;
  assign ang_cordic = z_sum[FRAC_SH +: ANG_W];

  // Zero-leg cases override the CORDIC angle
  always_comb begin
    degen_nxt = 1'b0;
    priority if (in_word.a_zero && in_word.b_zero) begin
      ang_a_nxt = '0;
      ang_b_nxt = '0;
      degen_nxt = 1'b1;
    end else if (in_word.a_zero) begin
      ang_a_nxt = '0;
      ang_b_nxt = DEG90_ANG;
    end else if (in_word.b_zero) begin
      ang_a_nxt = DEG90_ANG;
      ang_b_nxt = '0;
    end else begin
      ang_a_nxt = ang_cordic;
      ang_b_nxt = DEG90_ANG - ang_cordic;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hyp_r   <= hyp_nxt;
      ang_a_r <= ang_a_nxt;
      ang_b_r <= ang_b_nxt;
      degen_r <= degen_nxt;
    end
  end

  assign out_valid            = v_r;
  assign out_hypotenuse       = hyp_r;
  assign out_angle_opposite_a = ang_a_r;
  assign out_angle_opposite_b = ang_b_r;
  assign out_degenerate       = degen_r;

endmodule

// ===== rtl/core/right_triangle_magnitude_angles_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// right_triangle_magnitude_angles_top
// Takes two unsigned Q8.8 legs and returns the hypotenuse (Q9.8, rounded to
// nearest), the angle opposite each leg in degrees (Q7.8, the two summing to
// exactly 90.00) and a flag for two zero legs, which forces both angles to 0.
// The block is a fully pipelined datapath that accepts one word per clock
// unless the output is blocked and every stage is full, and returns one word
// per word taken. It has two squaring stages, one stage per square-root bit
// or CORDIC rotation, and the output stage. Every stage has its own valid bit
// and stalls only when full, so input keeps flowing into bubbles while a
// finished word waits at the output.
// ----------------------------------------------------------------------------
`include "right_triangle_magnitude_angles_top_macros.svh"

module right_triangle_magnitude_angles_top #(
  parameter int ITERATIONS = rtma_pkg::RTMA_ITERATIONS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rtma_pkg::LEG_W-1:0] in_leg_a,
  input  logic [rtma_pkg::LEG_W-1:0] in_leg_b,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rtma_pkg::HYP_W-1:0] out_hypotenuse,
  output logic [rtma_pkg::ANG_W-1:0] out_angle_opposite_a,
  output logic [rtma_pkg::ANG_W-1:0] out_angle_opposite_b,
  output logic                       out_degenerate
);
  import rtma_pkg::*;

  localparam int N_ITER = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
  localparam int N_STEP = (N_ITER > SQRT_STEPS) ? N_ITER : SQRT_STEPS;

  rtma_word_t word_s  [N_STEP+1];
  logic       valid_s [N_STEP+1];
  logic       ready_s [N_STEP+1];
  logic       out_all_zero;
  logic [ANG_W:0] out_angle_sum;

  // Squares and sum
  rtma_square u_square (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_leg_a  (in_leg_a),
    .in_leg_b  (in_leg_b),
    .out_valid (valid_s[0]),
    .out_ready (ready_s[0]),
    .out_word  (word_s[0])
  );

  // Root bits and rotations, one per stage
  for (genvar k = 0; k < N_STEP; k++) begin : g_step
    rtma_step #(
      .STEP       (k),
      .ITERATIONS (ITERATIONS)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (valid_s[k]),
      .in_ready  (ready_s[k]),
      .in_word   (word_s[k]),
      .out_valid (valid_s[k+1]),
      .out_ready (ready_s[k+1]),
      .out_word  (word_s[k+1])
    );
  end

  // Rounding and output register
  rtma_finish u_finish (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (valid_s[N_STEP]),
    .in_ready             (ready_s[N_STEP]),
    .in_word              (word_s[N_STEP]),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_hypotenuse       (out_hypotenuse),
    .out_angle_opposite_a (out_angle_opposite_a),
    .out_angle_opposite_b (out_angle_opposite_b),
    .out_degenerate       (out_degenerate)
  );

  // Terms for the output checks
  assign out_all_zero  = (out_hypotenuse == '0) && (out_angle_opposite_a == '0) &&
                         (out_angle_opposite_b == '0);
  assign out_angle_sum = {1'b0, out_angle_opposite_a} + {1'b0, out_angle_opposite_b};

  // Input backs up only when every stage is full and the output is blocked
  `RTMA_ASSERT_ALWAYS(a_full_stall, clk, rst_n, in_ready || (out_valid && !out_ready))

  // Two zero legs give an all-zero word
  `RTMA_ASSERT_IMP(a_degen_zero, clk, rst_n, out_valid && out_degenerate, out_all_zero)

  // Otherwise the angles are complementary
  `RTMA_ASSERT_IMP(a_angle_sum, clk, rst_n, out_valid && !out_degenerate, out_angle_sum == {1'b0, DEG90_ANG})

endmodule
